// ===== rtl/tlvd_pkg.sv =====
// Shared types and constants for the sensor TLV decoder.
package tlvd_pkg;

  // Limits of one payload
  localparam int unsigned MAX_RECORDS     = 32;
  localparam int unsigned MAX_VALUE_BYTES = 8;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned VALUE_LANES = VALUE_W / 8;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned LEN_W       = 4;

  // Result queue depth; a byte can produce two results
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Parse phase
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_HEADER,
    PH_VALUE
  } tlvd_phase_t;

  // One result beat
  typedef struct packed {
    logic               kind;
    logic [7:0]         sensor_type;
    logic [4:0]         sensor_index;
    logic [2:0]         format;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   value_bytes;
    logic [COUNT_W-1:0] record_count;
    logic               status;
    logic               last;
  } tlvd_result_t;

  // Results produced by one input beat, record first then status
  typedef struct packed {
    logic         rec_vld;
    logic         stat_vld;
    tlvd_result_t rec;
    tlvd_result_t stat;
  } tlvd_push_t;

endpackage

// ===== rtl/tlvd_parse.sv =====
// Byte parser: holds the record state and builds record and status results.
module tlvd_parse
  import tlvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        cfg_fire,
  input  logic [31:0] cfg_format_lengths,
  output tlvd_push_t  push
);

  tlvd_phase_t        phase_r, phase_nxt;
  logic [7:0]         held_type_r, held_type_nxt;
  logic [2:0]         held_format_r, held_format_nxt;
  logic [4:0]         held_index_r, held_index_nxt;
  logic [LEN_W-1:0]   held_len_r, held_len_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]   bytes_rem_r, bytes_rem_nxt;
  logic [COUNT_W-1:0] records_done_r, records_done_nxt;
  logic               error_seen_r, error_seen_nxt;
  logic [31:0]        fmt_len_r;

  logic               active;
  logic [2:0]         hdr_fmt;
  logic [LEN_W-1:0]   hdr_len;
  logic               limit_hit;
  logic               len_bad;
  logic               take_hdr;
  logic               hdr_err;
  logic               hdr_ok;
  logic               take_val;
  logic [LEN_W-1:0]   rem_dec;
  logic [2:0]         val_pos;
  logic [VALUE_W-1:0] acc_ins;
  logic               rec_done;
  logic               trunc;
  logic [COUNT_W-1:0] count_inc;

  // Decode of the current beat
  assign active    = in_fire && !error_seen_r;
  assign hdr_fmt   = in_data_byte[7:5];
  assign hdr_len   = fmt_len_r[{hdr_fmt, 2'b00} +: LEN_W];
  assign limit_hit = records_done_r >= COUNT_W'(MAX_RECORDS);
  assign len_bad   = hdr_len > LEN_W'(MAX_VALUE_BYTES);
  assign take_hdr  = active && (phase_r == PH_HEADER);
  assign hdr_err   = take_hdr && (limit_hit || len_bad);
  assign hdr_ok    = take_hdr && !limit_hit && !len_bad;
  assign take_val  = active && (phase_r == PH_VALUE);
  assign rem_dec   = bytes_rem_r - LEN_W'(1);
  assign val_pos   = 3'(held_len_r - bytes_rem_r);
  assign count_inc = records_done_r + COUNT_W'(1);

  assign rec_done = (hdr_ok && (hdr_len == '0)) || (take_val && (rem_dec == '0));
  // final beat leaves a value open
  assign trunc = in_last_byte &&
                 ((hdr_ok && (hdr_len != '0)) || (take_val && (rem_dec != '0)));

  // Drop the byte into its lane of the value
  always_comb begin
    acc_ins = acc_r;
    for (int i = 0; i < VALUE_LANES; i++) begin
      if (val_pos == 3'(i)) begin
        acc_ins[i*8 +: 8] = acc_r[i*8 +: 8] | in_data_byte;
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt        = phase_r;
    held_type_nxt    = held_type_r;
    held_format_nxt  = held_format_r;
    held_index_nxt   = held_index_r;
    held_len_nxt     = held_len_r;
    acc_nxt          = acc_r;
    bytes_rem_nxt    = bytes_rem_r;
    records_done_nxt = records_done_r;
    error_seen_nxt   = error_seen_r;
    if (active) begin
      case (phase_r)
        PH_TYPE: begin
          held_type_nxt = in_data_byte;
          phase_nxt     = PH_HEADER;
        end
        PH_HEADER: begin
          if (limit_hit) begin
            error_seen_nxt = 1'b1;
          end else begin
            held_format_nxt = hdr_fmt;
            held_index_nxt  = in_data_byte[4:0];
            if (len_bad) begin
              error_seen_nxt = 1'b1;
            end else begin
              held_len_nxt  = hdr_len;
              bytes_rem_nxt = hdr_len;
              acc_nxt       = '0;
              phase_nxt     = (hdr_len == '0) ? PH_TYPE : PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          acc_nxt       = acc_ins;
          bytes_rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
      if (rec_done) begin
        records_done_nxt = count_inc;
      end
    end
    // end of payload clears everything but the config
    if (in_fire && in_last_byte) begin
      phase_nxt        = PH_TYPE;
      held_type_nxt    = '0;
      held_format_nxt  = '0;
      held_index_nxt   = '0;
      held_len_nxt     = '0;
      acc_nxt          = '0;
      bytes_rem_nxt    = '0;
      records_done_nxt = '0;
      error_seen_nxt   = 1'b0;
    end
  end

  // Result beats
  always_comb begin
    push.rec_vld           = rec_done;
    push.rec.kind          = KIND_RECORD;
    push.rec.sensor_type   = held_type_r;
    push.rec.sensor_index  = take_hdr ? in_data_byte[4:0] : held_index_r;
    push.rec.format        = take_hdr ? hdr_fmt : held_format_r;
    push.rec.value         = take_hdr ? '0 : acc_ins;
    push.rec.value_bytes   = take_hdr ? hdr_len : held_len_r;
    push.rec.record_count  = count_inc;
    push.rec.status        = STATUS_OK;
    push.rec.last          = 1'b0;

    push.stat_vld          = in_fire && in_last_byte;
    push.stat.kind         = KIND_STATUS;
    push.stat.sensor_type  = '0;
    push.stat.sensor_index = '0;
    push.stat.format       = '0;
    push.stat.value        = '0;
    push.stat.value_bytes  = '0;
    push.stat.record_count = rec_done ? count_inc : records_done_r;
    push.stat.status       = (error_seen_r || hdr_err || trunc) ? STATUS_ERR : STATUS_OK;
    push.stat.last         = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TYPE;
      held_type_r    <= '0;
      held_format_r  <= '0;
      held_index_r   <= '0;
      held_len_r     <= '0;
      acc_r          <= '0;
      bytes_rem_r    <= '0;
      records_done_r <= '0;
      error_seen_r   <= 1'b0;
      fmt_len_r      <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_type_r    <= held_type_nxt;
      held_format_r  <= held_format_nxt;
      held_index_r   <= held_index_nxt;
      held_len_r     <= held_len_nxt;
      acc_r          <= acc_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
      records_done_r <= records_done_nxt;
      error_seen_r   <= error_seen_nxt;
      if (cfg_fire) begin
        fmt_len_r <= cfg_format_lengths;
      end
    end
  end

  // Checks
  a_val_phase_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VALUE) |-> (bytes_rem_r != '0 && bytes_rem_r <= held_len_r))
    else $error("value phase with bad remaining byte count");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    records_done_r <= COUNT_W'(MAX_RECORDS))
    else $error("record count beyond limit");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (phase_r == PH_TYPE && records_done_r == '0 && !error_seen_r))
    else $error("payload state not cleared after final beat");

endmodule

// ===== rtl/tlvd_queue.sv =====
// Result queue: takes up to two results per cycle and hands out one per beat.
module tlvd_queue
  import tlvd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tlvd_push_t   push,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output tlvd_result_t out_res
);

  tlvd_result_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  logic [1:0]        n_push;

  // Space for a two-result beat
  assign room      = count_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push.rec_vld} + {1'b0, push.stat_vld};

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  // Storage, record ahead of status
  always_ff @(posedge clk) begin
    if (push.rec_vld) begin
      mem_r[wr_ptr_r] <= push.rec;
      if (push.stat_vld) begin
        mem_r[wr_ptr_r + QPTR_W'(1)] <= push.stat;
      end
    end else if (push.stat_vld) begin
      mem_r[wr_ptr_r] <= push.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.rec_vld || push.stat_vld) |-> room)
    else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r))
    else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/sensor_tlv_decoder.sv =====
// Top level of the sensor TLV decoder: byte parser and result queue.
//
// Accepts one payload byte per cycle and answers each completed record with a
// record beat, and the final byte of a payload with a status beat (record count
// and error flag) that follows any record finished on that same byte. A byte
// is parsed in the cycle of its beat against the held record state; results go
// into a four-entry queue whose head drives the out_ ports, so the earliest
// result shows in the cycle after its byte. The input takes a byte whenever the
// queue has two free entries, which gives one byte per cycle while the output
// drains; only a final byte that also ends a record adds a second result.
// The length table register is always ready; writing it between payloads is up to the user.
module sensor_tlv_decoder
  import tlvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [7:0]         out_sensor_type,
  output logic [4:0]         out_sensor_index,
  output logic [2:0]         out_format,
  output logic [VALUE_W-1:0] out_value,
  output logic [LEN_W-1:0]   out_value_bytes,
  output logic [COUNT_W-1:0] out_record_count,
  output logic               out_status,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_format_lengths
);

  tlvd_push_t   push;
  tlvd_result_t out_res;
  logic         room;
  logic         in_fire;
  logic         cfg_fire;

  assign in_ready  = room;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  tlvd_parse u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_fire            (in_fire),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .cfg_fire           (cfg_fire),
    .cfg_format_lengths (cfg_format_lengths),
    .push               (push)
  );

  tlvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields
  assign out_kind         = out_res.kind;
  assign out_sensor_type  = out_res.sensor_type;
  assign out_sensor_index = out_res.sensor_index;
  assign out_format       = out_res.format;
  assign out_value        = out_res.value;
  assign out_value_bytes  = out_res.value_bytes;
  assign out_record_count = out_res.record_count;
  assign out_status       = out_res.status;
  assign out_last         = out_res.last;

endmodule
